// ----- rtl/ssp_pkg.sv -----
`default_nettype none

package ssp_pkg;

  // Field widths of the request, response and configuration registers.
  localparam int OP_W    = 2;
  localparam int ANGLE_W = 12;
  localparam int SPEED_W = 10;
  localparam int PULSE_W = 16;
  localparam int TICK_W  = 10;
  localparam int FREQ_W  = 10;
  localparam int DUTY_W  = 16;
  localparam int STEP_W  = 14;

  // Operation codes carried in the request.
  localparam logic [OP_W-1:0] OP_SET     = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
  localparam logic [OP_W-1:0] OP_DISABLE = 2'd2;

  // Register indexes on the configuration port (byte address / 4).
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_MIN_PULSE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_PULSE = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TICK      = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_FREQ      = 2'd3;
  localparam int APB_ADDR_W = REG_IDX_W + 2;
  localparam int APB_DATA_W = 32;

  // Register reset values.
  localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 16'd500;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 16'd2500;
  localparam logic [TICK_W-1:0]  TICK_RST      = 10'd20;
  localparam logic [FREQ_W-1:0]  FREQ_RST      = 10'd50;

  // Angle and step limits, in 1/16 degree.
  localparam logic [ANGLE_W-1:0] ANGLE_FULL  = 12'd2880;
  localparam logic [ANGLE_W-1:0] ANGLE_RST   = 12'd1440;
  localparam logic [STEP_W-1:0]  STEP_FLOOR  = 14'd8;
  localparam logic [STEP_W-1:0]  STEP_CEIL   = 14'd16383;

  // Step size is floor(speed * tick * 16 / 1000) = floor(2n / 125). It is
  // formed as (2n * ceil(2^28 / 125)) >> 28, which is exact for 2n < 2^21.
  localparam int SPDTICK_W   = SPEED_W + TICK_W;
  localparam int RECIP_W     = 22;
  localparam int RECIP_SHIFT = 28;
  localparam logic [RECIP_W-1:0] RECIP_125 = 22'd2147484;
  localparam int RECIP_PROD_W = SPDTICK_W + 1 + RECIP_W;
  localparam int STEP_Q_W     = RECIP_PROD_W - RECIP_SHIFT;

  // Duty: the scaled pulse width min*(2880-a) + max*a fits 28 bits. The
  // divisor 2880 * 10^6 equals 2^12 * 703125; the power of two is a shift.
  // The rest is floor(z * M / 2^55) with M = ceil(2^55 / 703125), exact for
  // z < 703125 * 2^16. M is kept as two 18-bit halves.
  localparam int PSUM_W      = PULSE_W + ANGLE_W;
  localparam int SCALED_W    = PSUM_W + FREQ_W;
  localparam int SCALE_SHIFT = 12;
  localparam int DIVN_W      = 36;
  localparam int QUO_W       = DUTY_W;
  localparam int RECIP_D_SPLIT = 18;
  localparam int RECIP_D_SHIFT = 55;
  localparam logic [RECIP_D_SPLIT-1:0] RECIP_D_HI = 18'd195468;
  localparam logic [RECIP_D_SPLIT-1:0] RECIP_D_LO = 18'd192369;
  localparam logic [DIVN_W-1:0] DIV_LIMIT = 36'd46080000000;
  localparam logic [DUTY_W-1:0] DUTY_SAT  = 16'hFFFF;

  localparam int DUTY_BITS_DEF = 16;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [ANGLE_W-1:0] target_angle;
    logic [SPEED_W-1:0] ramp_speed;
  } req_t;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty;
    logic [ANGLE_W-1:0] current_angle;
    logic               moving;
    logic               enabled;
  } rsp_t;

  typedef struct packed {
    logic [PULSE_W-1:0] min_pulse_us;
    logic [PULSE_W-1:0] max_pulse_us;
    logic [TICK_W-1:0]  tick_interval_ms;
    logic [FREQ_W-1:0]  pwm_freq_hz;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic step_mul;
    logic step_recip;
    logic step_clamp;
    logic step_apply;
    logic mul_a;
    logic mul_b;
    logic mul_f;
    logic div_start;
    logic rsp_load;
  } cmd_t;

  typedef struct packed {
    logic set_ramp;
    logic div_done;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/ssp_div.sv -----
`default_nettype none

// Divides by the fixed constant 703125 with a reciprocal multiply spread over
// registered steps: the low half of the reciprocal on the start edge, then the
// high half, then the aligned sum. The dividend must be below 703125 * 2^16
// so the quotient fits 16 bits.
module ssp_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [ssp_pkg::DIVN_W-1:0] dividend,
  output logic      [ssp_pkg::QUO_W-1:0]  quotient,
  output logic                            done
);

  localparam int PROD_W  = ssp_pkg::DIVN_W + ssp_pkg::RECIP_D_SPLIT;
  localparam int SUM_W   = PROD_W + 1;
  localparam int SUM_LSB = ssp_pkg::RECIP_D_SHIFT - ssp_pkg::RECIP_D_SPLIT;

  logic [ssp_pkg::DIVN_W-1:0] num;
  logic [PROD_W-1:0]          prod_lo;
  logic [PROD_W-1:0]          prod_hi;
  logic [SUM_W-1:0]           prod_sum;
  logic [1:0]                 phase;

  // The low product's bits below the split never carry into the quotient.
  assign prod_sum = {1'b0, prod_hi} +
                    SUM_W'(prod_lo[PROD_W-1:ssp_pkg::RECIP_D_SPLIT]);
  assign done     = phase[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else begin
      phase <= {phase[0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num     <= dividend;
      prod_lo <= PROD_W'(dividend) * PROD_W'(ssp_pkg::RECIP_D_LO);
    end
    if (phase[0]) begin
      prod_hi <= PROD_W'(num) * PROD_W'(ssp_pkg::RECIP_D_HI);
    end
    if (phase[1]) begin
      quotient <= prod_sum[SUM_LSB+ssp_pkg::QUO_W-1:SUM_LSB];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ssp_datapath.sv -----
`default_nettype none

// Angle state, ramp step sizing and the duty computation.
module ssp_datapath #(
  parameter int DUTY_BITS = ssp_pkg::DUTY_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ssp_pkg::cmd_t cmd,
  output ssp_pkg::sts_t      sts,
  input  wire ssp_pkg::cfg_t cfg,
  input  wire ssp_pkg::req_t req_data,
  output ssp_pkg::rsp_t      rsp_data
);

  localparam int SHW  = ssp_pkg::SCALED_W + DUTY_BITS;
  localparam int ZW   = SHW - ssp_pkg::SCALE_SHIFT;
  localparam int CMPW = (ZW > ssp_pkg::DIVN_W) ? ZW : ssp_pkg::DIVN_W;

  // Architectural state.
  logic [ssp_pkg::ANGLE_W-1:0] cur;
  logic [ssp_pkg::ANGLE_W-1:0] tgt;
  logic [ssp_pkg::STEP_W-1:0]  step_size;
  logic                        enabled;

  // Working registers.
  logic [ssp_pkg::SPEED_W-1:0]      spd;
  logic [ssp_pkg::SPDTICK_W-1:0]    spd_tick;
  logic [ssp_pkg::RECIP_PROD_W-1:0] recip_prod;
  logic [ssp_pkg::PSUM_W-1:0]       part_a;
  logic [ssp_pkg::PSUM_W-1:0]       psum;
  logic [ssp_pkg::SCALED_W-1:0]     scaled;
  logic                             sat;

  logic [ssp_pkg::ANGLE_W-1:0]  tgt_clamped;
  logic [ssp_pkg::ANGLE_W-1:0]  cur_stepped;
  logic [ssp_pkg::ANGLE_W+2:0]  up_sum;
  logic [ssp_pkg::ANGLE_W+2:0]  tgt_plus;
  logic [ssp_pkg::STEP_Q_W-1:0] step_q;
  logic [ssp_pkg::STEP_W-1:0]   step_clamped;
  logic [SHW-1:0]               scaled_sh;
  logic [CMPW-1:0]              z_ext;
  logic [ssp_pkg::QUO_W-1:0]    quotient;
  logic                         div_done;

  assign tgt_clamped = (req_data.target_angle > ssp_pkg::ANGLE_FULL) ?
                       ssp_pkg::ANGLE_FULL : req_data.target_angle;

  // One ramp step toward the target, stopping on it rather than past it.
  assign up_sum   = {3'b000, cur} + {1'b0, step_size};
  assign tgt_plus = {3'b000, tgt} + {1'b0, step_size};

  always_comb begin
    if (cur < tgt) begin
      cur_stepped = (up_sum > {3'b000, tgt}) ? tgt : up_sum[ssp_pkg::ANGLE_W-1:0];
    end else if (cur > tgt) begin
      cur_stepped = ({3'b000, cur} > tgt_plus) ?
                    (cur - step_size[ssp_pkg::ANGLE_W-1:0]) : tgt;
    end else begin
      cur_stepped = cur;
    end
  end

  assign step_q = recip_prod[ssp_pkg::RECIP_PROD_W-1:ssp_pkg::RECIP_SHIFT];

  always_comb begin
    if (step_q < ssp_pkg::STEP_Q_W'(ssp_pkg::STEP_FLOOR)) begin
      step_clamped = ssp_pkg::STEP_FLOOR;
    end else if (step_q > ssp_pkg::STEP_Q_W'(ssp_pkg::STEP_CEIL)) begin
      step_clamped = ssp_pkg::STEP_CEIL;
    end else begin
      step_clamped = step_q[ssp_pkg::STEP_W-1:0];
    end
  end

  assign scaled_sh = {scaled, {DUTY_BITS{1'b0}}};
  assign z_ext     = CMPW'(scaled_sh[SHW-1:ssp_pkg::SCALE_SHIFT]);

  assign sts.set_ramp = (req_data.operation == ssp_pkg::OP_SET) &&
                        (req_data.ramp_speed != '0);
  assign sts.div_done = div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur       <= ssp_pkg::ANGLE_RST;
      tgt       <= ssp_pkg::ANGLE_RST;
      step_size <= ssp_pkg::STEP_FLOOR;
      enabled   <= 1'b1;
    end else begin
      if (cmd.accept) begin
        case (req_data.operation)
          ssp_pkg::OP_SET: begin
            tgt     <= tgt_clamped;
            enabled <= 1'b1;
            if (req_data.ramp_speed == '0) begin
              cur <= tgt_clamped;
            end
          end
          ssp_pkg::OP_TICK: begin
            cur <= cur_stepped;
          end
          ssp_pkg::OP_DISABLE: begin
            enabled <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (cmd.step_clamp) begin
        step_size <= step_clamped;
      end
      if (cmd.step_apply) begin
        cur <= cur_stepped;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      spd <= req_data.ramp_speed;
    end
    if (cmd.step_mul) begin
      spd_tick <= ssp_pkg::SPDTICK_W'(spd) * ssp_pkg::SPDTICK_W'(cfg.tick_interval_ms);
    end
    if (cmd.step_recip) begin
      recip_prod <= ssp_pkg::RECIP_PROD_W'({spd_tick, 1'b0}) *
                    ssp_pkg::RECIP_PROD_W'(ssp_pkg::RECIP_125);
    end
    if (cmd.mul_a) begin
      part_a <= ssp_pkg::PSUM_W'(cfg.min_pulse_us) *
                ssp_pkg::PSUM_W'(ssp_pkg::ANGLE_FULL - cur);
    end
    if (cmd.mul_b) begin
      psum <= part_a + ssp_pkg::PSUM_W'(cfg.max_pulse_us) * ssp_pkg::PSUM_W'(cur);
    end
    if (cmd.mul_f) begin
      scaled <= ssp_pkg::SCALED_W'(psum) * ssp_pkg::SCALED_W'(cfg.pwm_freq_hz);
    end
    if (cmd.div_start) begin
      sat <= (z_ext >= CMPW'(ssp_pkg::DIV_LIMIT));
    end
    if (cmd.rsp_load) begin
      if (!enabled) begin
        rsp_data.duty <= '0;
      end else if (sat) begin
        rsp_data.duty <= ssp_pkg::DUTY_SAT;
      end else begin
        rsp_data.duty <= quotient;
      end
      rsp_data.current_angle <= cur;
      rsp_data.moving        <= (cur != tgt);
      rsp_data.enabled       <= enabled;
    end
  end

  ssp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (z_ext[ssp_pkg::DIVN_W-1:0]),
    .quotient (quotient),
    .done     (div_done)
  );

endmodule

`default_nettype wire

// ----- rtl/ssp_ctrl.sv -----
`default_nettype none

// Sequencer: walks one request through step sizing (ramping sets only),
// the duty multiplies and the divider, then loads the response register.
module ssp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output ssp_pkg::cmd_t      cmd,
  input  wire ssp_pkg::sts_t sts
);

  typedef enum logic [10:0] {
    S_IDLE       = 11'b000_0000_0001,
    S_STEP_MUL   = 11'b000_0000_0010,
    S_STEP_RECIP = 11'b000_0000_0100,
    S_STEP_CLAMP = 11'b000_0000_1000,
    S_STEP_APPLY = 11'b000_0001_0000,
    S_MUL_A      = 11'b000_0010_0000,
    S_MUL_B      = 11'b000_0100_0000,
    S_MUL_F      = 11'b000_1000_0000,
    S_DIV_START  = 11'b001_0000_0000,
    S_DIV_RUN    = 11'b010_0000_0000,
    S_DONE       = 11'b100_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = sts.set_ramp ? S_STEP_MUL : S_MUL_A;
        end
      end
      S_STEP_MUL: begin
        cmd.step_mul = 1'b1;
        state_next   = S_STEP_RECIP;
      end
      S_STEP_RECIP: begin
        cmd.step_recip = 1'b1;
        state_next     = S_STEP_CLAMP;
      end
      S_STEP_CLAMP: begin
        cmd.step_clamp = 1'b1;
        state_next     = S_STEP_APPLY;
      end
      S_STEP_APPLY: begin
        cmd.step_apply = 1'b1;
        state_next     = S_MUL_A;
      end
      S_MUL_A: begin
        cmd.mul_a  = 1'b1;
        state_next = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.mul_b  = 1'b1;
        state_next = S_MUL_F;
      end
      S_MUL_F: begin
        cmd.mul_f  = 1'b1;
        state_next = S_DIV_START;
      end
      S_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        if (sts.div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.rsp_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/servo_slew_pwm_duty_core.sv -----
// Servo slew limiter with a PWM duty output.
// Requests arrive on req_valid/req_data and are taken at a clock edge where
// req_valid is high and req_stall is low. A set request clamps the target to
// 180 degrees and, at nonzero speed, sizes a ramp step and takes the first
// step; a tick request moves the angle one step; a disable request forces a
// duty of zero until the next set. Every request yields exactly one response
// on rsp_valid/rsp_data, taken where rsp_valid is high and rsp_stall is low.
// The four settings registers sit on an APB port at byte addresses 0, 4, 8
// and 12; they are meant to be written only while the block is idle.
// For each request the pulse width is formed by the min and max multiplies
// and scaled by the frequency multiply, then divided into a duty word by
// the reciprocal multiply; a ramping set first sizes the step and takes it.
// One request is worked on at a time, so a request is taken only once the
// last response has been loaded. The response sits in an output register,
// so a new request is taken while a stalled response still waits; only the
// next response then waits for the receiver. Synchronous reset puts the
// servo at ninety degrees, target equal, half-degree step, output enabled,
// and the registers at 500 us, 2500 us, 20 ms and 50 Hz.
`default_nettype none

module servo_slew_pwm_duty_core #(
  // Duty resolution in bits, 8 to 20.
  parameter int DUTY_BITS = ssp_pkg::DUTY_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           req_valid,
  output logic                                req_stall,
  input  wire ssp_pkg::req_t                  req_data,
  output logic                                rsp_valid,
  input  wire logic                           rsp_stall,
  output ssp_pkg::rsp_t                       rsp_data,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ssp_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [ssp_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [ssp_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready
);

  ssp_pkg::cfg_t cfg;
  ssp_pkg::cmd_t cmd;
  ssp_pkg::sts_t sts;

  logic                            cfg_write;
  logic [ssp_pkg::REG_IDX_W-1:0]   reg_idx;

  // The port never inserts wait states.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[ssp_pkg::APB_ADDR_W-1:2];

  // Settings registers. Values are taken as written, truncated to their width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_pulse_us     <= ssp_pkg::MIN_PULSE_RST;
      cfg.max_pulse_us     <= ssp_pkg::MAX_PULSE_RST;
      cfg.tick_interval_ms <= ssp_pkg::TICK_RST;
      cfg.pwm_freq_hz      <= ssp_pkg::FREQ_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        ssp_pkg::REG_MIN_PULSE: cfg.min_pulse_us     <= pwdata[ssp_pkg::PULSE_W-1:0];
        ssp_pkg::REG_MAX_PULSE: cfg.max_pulse_us     <= pwdata[ssp_pkg::PULSE_W-1:0];
        ssp_pkg::REG_TICK:      cfg.tick_interval_ms <= pwdata[ssp_pkg::TICK_W-1:0];
        ssp_pkg::REG_FREQ:      cfg.pwm_freq_hz      <= pwdata[ssp_pkg::FREQ_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read back, zero-extended to the bus width.
  always_comb begin
    case (reg_idx)
      ssp_pkg::REG_MIN_PULSE: prdata = ssp_pkg::APB_DATA_W'(cfg.min_pulse_us);
      ssp_pkg::REG_MAX_PULSE: prdata = ssp_pkg::APB_DATA_W'(cfg.max_pulse_us);
      ssp_pkg::REG_TICK:      prdata = ssp_pkg::APB_DATA_W'(cfg.tick_interval_ms);
      ssp_pkg::REG_FREQ:      prdata = ssp_pkg::APB_DATA_W'(cfg.pwm_freq_hz);
      default:                prdata = '0;
    endcase
  end

  // The controller sequences each request; the datapath holds the servo
  // state, the step and duty arithmetic, and the response register.
  ssp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  ssp_datapath #(
    .DUTY_BITS (DUTY_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .cfg      (cfg),
    .req_data (req_data),
    .rsp_data (rsp_data)
  );

  // The reported angle never leaves the 0 to 180 degree range.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_data.current_angle <= ssp_pkg::ANGLE_FULL))
    else $error("response angle beyond 180 degrees");

  // A disabled output always reports a zero duty.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_data.enabled) |-> (rsp_data.duty == '0))
    else $error("nonzero duty while disabled");

  // Once a request is taken the block is busy on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while another is in progress");

endmodule

`default_nettype wire

// ----- verif/tb_servo_slew_pwm_duty_core.sv -----
`timescale 1ns / 100ps

// Testbench for the servo slew limiter with PWM duty output.
// A queue of servo requests is filled by the stimulus process and drained by a
// clocked driver. The driver keeps its own model of the servo angle, target,
// ramp step and settings registers, and forms the expected status for every
// request at the clock edge where the block takes it. A clocked monitor checks
// each response against the oldest expected status.
module tb_servo_slew_pwm_duty_core;
  import ssp_pkg::*;

  localparam int DUTY_BITS = DUTY_BITS_DEF;
  // Operation code three has no meaning; the block only reports its status.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // Pulse width in 1/16 us-degrees is divided by 2880 * 10^6 to form the duty.
  localparam longint unsigned DUTY_DIVISOR = 64'd2880000000;
  localparam int N_SETTINGS = 6;
  localparam int MOVES_PER_SETTING = 305;
  localparam int SETTLE_CYCLES = 30;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Block inputs all start at known values.
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  req_t                  req_data = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  rsp_t                  rsp_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Model of the settings registers, as the block holds them after reset.
  logic [PULSE_W-1:0] min_us = MIN_PULSE_RST;
  logic [PULSE_W-1:0] max_us = MAX_PULSE_RST;
  logic [TICK_W-1:0]  tick_ms = TICK_RST;
  logic [FREQ_W-1:0]  freq_hz = FREQ_RST;

  // Model of the servo state.
  int unsigned angle_now = 32'(ANGLE_RST);
  int unsigned angle_goal = 32'(ANGLE_RST);
  int unsigned ramp_step = 32'(STEP_FLOOR);
  bit          drive_on = 1'b1;

  req_t request_q[$];
  rsp_t status_expect_q[$];
  rsp_t status_want;

  int  n_queued = 0;
  int  n_accepted = 0;
  int  n_checked = 0;
  int  n_errors = 0;
  int  n_saturated = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  bit  idling_on = 1'b1;

  servo_slew_pwm_duty_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The duty word is the pulse width as a fraction of the PWM frame, scaled
  // to the duty resolution. A reversed pulse range simply runs downward, and
  // a pulse width at or below zero gives zero duty.
  function automatic logic [DUTY_W-1:0] duty_of_angle(input int unsigned angle);
    longint          pulse;
    longint unsigned scaled;
    pulse = longint'(min_us) * 2880
          + longint'(angle) * (longint'(max_us) - longint'(min_us));
    if (pulse <= 0) return '0;
    scaled = pulse;
    scaled = (scaled * freq_hz) << DUTY_BITS;
    scaled = scaled / DUTY_DIVISOR;
    if (scaled > 64'd65535) return DUTY_SAT;
    return scaled[DUTY_W-1:0];
  endfunction

  // One ramp step toward the target, stopping on it rather than overshooting.
  function automatic void ramp_toward_goal();
    if (angle_now < angle_goal) begin
      angle_now = (angle_now + ramp_step > angle_goal) ? angle_goal : angle_now + ramp_step;
    end else if (angle_now > angle_goal) begin
      angle_now = (angle_now > angle_goal + ramp_step) ? angle_now - ramp_step : angle_goal;
    end
  endfunction

  // Applies one request to the servo model and returns the status it causes.
  function automatic rsp_t servo_predict(input req_t r);
    int unsigned goal;
    int unsigned stride;
    rsp_t        s;
    case (r.operation)
      OP_SET: begin
        goal = (r.target_angle > ANGLE_FULL) ? 32'(ANGLE_FULL) : 32'(r.target_angle);
        angle_goal = goal;
        drive_on = 1'b1;
        if (r.ramp_speed == '0) begin
          angle_now = goal;
        end else begin
          // Degrees per second times milliseconds, in 1/16 degree.
          stride = (int'(r.ramp_speed) * int'(tick_ms) * 16) / 1000;
          if (stride < STEP_FLOOR) stride = 32'(STEP_FLOOR);
          if (stride > STEP_CEIL) stride = 32'(STEP_CEIL);
          ramp_step = stride;
          ramp_toward_goal();
        end
      end
      OP_TICK: begin
        ramp_toward_goal();
      end
      OP_DISABLE: begin
        drive_on = 1'b0;
      end
      default: begin
      end
    endcase
    s.duty = drive_on ? duty_of_angle(angle_now) : '0;
    s.current_angle = angle_now[ANGLE_W-1:0];
    s.moving = (angle_now != angle_goal);
    s.enabled = drive_on;
    if (s.duty == DUTY_SAT) n_saturated++;
    return s;
  endfunction

  function automatic void queue_request(input logic [OP_W-1:0] op,
                                        input logic [ANGLE_W-1:0] tgt,
                                        input logic [SPEED_W-1:0] spd);
    req_t r;
    r.operation = op;
    r.target_angle = tgt;
    r.ramp_speed = spd;
    request_q.push_back(r);
    n_queued++;
  endfunction

  // Request driver. The expected status is formed at the edge where the block
  // takes a request; a new request goes up in the same step unless a random
  // gap is due, so valid stays high across back-to-back requests.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (req_valid && !req_stall) begin
        status_expect_q.push_back(servo_predict(req_data));
        n_accepted++;
      end
      if (!req_valid || !req_stall) begin
        if (send_gap > 0) begin
          req_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (request_q.size() > 0) begin
          req_data <= request_q.pop_front();
          req_valid <= 1'b1;
          if (idling_on && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 7);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor with random stall bursts.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (status_expect_q.size() == 0) begin
          $error("response with no request waiting: %h", rsp_data);
          n_errors++;
        end else begin
          status_want = status_expect_q.pop_front();
          n_checked++;
          if (rsp_data.duty !== status_want.duty) begin
            $error("duty: expected %0d, got %0d", status_want.duty, rsp_data.duty);
            n_errors++;
          end
          if (rsp_data.current_angle !== status_want.current_angle) begin
            $error("current_angle: expected %0d, got %0d",
                   status_want.current_angle, rsp_data.current_angle);
            n_errors++;
          end
          if (rsp_data.moving !== status_want.moving) begin
            $error("moving: expected %0b, got %0b", status_want.moving, rsp_data.moving);
            n_errors++;
          end
          if (rsp_data.enabled !== status_want.enabled) begin
            $error("enabled: expected %0b, got %0b", status_want.enabled, rsp_data.enabled);
            n_errors++;
          end
        end
      end
      if (stall_left > 0) begin
        rsp_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        rsp_stall <= 1'b1;
        stall_left <= $urandom_range(0, 6);
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // Holds off until every queued request has been taken and answered, then
  // lets the block settle so that a register write finds it idle.
  task automatic wait_quiet();
    do @(posedge clk); while (n_accepted != n_queued || status_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then the access cycle in which the register loads.
  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MIN_PULSE: min_us = value[PULSE_W-1:0];
      REG_MAX_PULSE: max_us = value[PULSE_W-1:0];
      REG_TICK:      tick_ms = value[TICK_W-1:0];
      default:       freq_hz = value[FREQ_W-1:0];
    endcase
  endtask

  // Random traffic, mostly set requests followed by a run of ticks so that the
  // servo ramps over long distances. Disables, unused codes and stray set, tick
  // or disable requests are mixed in. Unused codes do not count toward the total.
  task automatic queue_servo_moves(input int count);
    int                 left;
    int                 n_ticks;
    int                 pick;
    logic [ANGLE_W-1:0] goal;
    logic [SPEED_W-1:0] spd;
    left = count;
    while (left > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        goal = ANGLE_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                    : $urandom_range(0, 2880));
        case ($urandom_range(0, 3))
          0:       spd = '0;
          1:       spd = SPEED_W'($urandom_range(1, 30));
          2:       spd = SPEED_W'($urandom_range(1, 200));
          default: spd = SPEED_W'($urandom_range(0, 1023));
        endcase
        queue_request(OP_SET, goal, spd);
        n_ticks = $urandom_range(0, 40);
        // Ticks ignore the angle and speed fields, so those carry noise.
        repeat (n_ticks) queue_request(OP_TICK, ANGLE_W'($urandom), SPEED_W'($urandom));
        left -= 1 + n_ticks;
      end else if (pick < 82) begin
        // A disable while ramping; the angle keeps moving but duty is zero.
        queue_request(OP_DISABLE, ANGLE_W'($urandom), SPEED_W'($urandom));
        n_ticks = $urandom_range(0, 5);
        repeat (n_ticks) queue_request(OP_TICK, ANGLE_W'($urandom), SPEED_W'($urandom));
        left -= 1 + n_ticks;
      end else if (pick < 88) begin
        queue_request(OP_UNUSED, ANGLE_W'($urandom), SPEED_W'($urandom));
      end else begin
        queue_request(OP_W'($urandom_range(0, 2)), ANGLE_W'($urandom), SPEED_W'($urandom));
        left--;
      end
    end
  endtask

  initial begin
    // Register settings for each phase: moderate values, the widest pulse
    // range at the top frequency and tick (duty and step both saturate), a
    // reversed range at the slowest rates, zero tick and zero frequency, a
    // random set, and finally the reset values again.
    int unsigned set_min[N_SETTINGS];
    int unsigned set_max[N_SETTINGS];
    int unsigned set_tick[N_SETTINGS];
    int unsigned set_freq[N_SETTINGS];

    set_min  = '{1000, 0,     65535, 2500, 0, 500};
    set_max  = '{2000, 65535, 0,     500,  0, 2500};
    set_tick = '{10,   1023,  1,     0,    0, 20};
    set_freq = '{333,  1023,  1,     0,    0, 50};

    set_min[4] = $urandom_range(0, 65535);
    set_max[4] = $urandom_range(0, 65535);
    set_tick[4] = $urandom_range(1, 1000);
    set_freq[4] = $urandom_range(1, 1000);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed requests under the reset settings.
    queue_request(OP_TICK, '0, '0);              // tick at the target after reset
    queue_request(OP_SET, '0, '0);               // jump to zero degrees
    queue_request(OP_SET, 12'hFFF, '0);          // far above range, clamped
    queue_request(OP_SET, ANGLE_FULL, '0);       // exactly 180 degrees
    queue_request(OP_SET, 12'd2881, '0);         // just above range
    queue_request(OP_SET, '0, 10'h3FF);          // fastest ramp, one step
    queue_request(OP_SET, 12'd40, 10'd1);        // slowest ramp, floor step
    queue_request(OP_TICK, '0, '0);
    queue_request(OP_TICK, '0, '0);
    queue_request(OP_SET, 12'd2870, 10'd1);      // long ramp upward
    queue_request(OP_TICK, 12'hFFF, 10'h3FF);
    queue_request(OP_DISABLE, '0, '0);
    queue_request(OP_TICK, '0, '0);              // ramps while disabled
    queue_request(OP_DISABLE, 12'hFFF, 10'h3FF); // disable twice
    queue_request(OP_UNUSED, 12'hAAA, 10'h155);  // unused code, status only
    queue_request(OP_SET, ANGLE_RST, 10'd5);     // set while disabled re-enables
    queue_request(OP_TICK, '0, '0);
    queue_request(OP_SET, 12'hAAA, 10'h155);
    queue_request(OP_SET, 12'h555, 10'h2AA);
    queue_request(OP_TICK, '0, '0);
    queue_request(OP_UNUSED, 12'h555, 10'h2AA);
    wait_quiet();

    for (int ph = 0; ph < N_SETTINGS; ph++) begin
      reg_write(REG_MIN_PULSE, set_min[ph]);
      reg_write(REG_MAX_PULSE, set_max[ph]);
      reg_write(REG_TICK, set_tick[ph]);
      reg_write(REG_FREQ, set_freq[ph]);
      // The last phase runs with neither side idling.
      idling_on <= (ph != N_SETTINGS - 1);
      queue_servo_moves(MOVES_PER_SETTING);
      wait_quiet();
    end

    $display("summary: %0d responses checked over %0d register settings, %0d at full duty",
             n_checked, N_SETTINGS + 1, n_saturated);
    if (n_errors == 0 && status_expect_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Upper bound on the run, several times the slowest correct one.
  initial begin
    #(5_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- servo_slew_pwm_duty_core.f -----
rtl/ssp_pkg.sv
rtl/ssp_div.sv
rtl/ssp_datapath.sv
rtl/ssp_ctrl.sv
rtl/servo_slew_pwm_duty_core.sv
verif/tb_servo_slew_pwm_duty_core.sv
